// ===== hdl/pcrw_pkg.sv =====
// Shared types, codes and constants of the round-robin write-back page cache.
package pcrw_pkg;

	// default number of cache slots
	localparam int SLOTS_DEFAULT = 16;

	// field widths of the words on the two channels
	localparam int OP_W     = 3;
	localparam int ADDR_W   = 32;
	localparam int SEL_W    = 4;
	localparam int HANDLE_W = 16;
	localparam int KIND_W   = 2;

	// width that holds any slot count up to 127 for range checks
	localparam int SLOT_CMP_W = 7;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// operation codes on the request channel
	localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd0;
	localparam logic [OP_W-1:0] OP_PLACE       = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK_DIRTY  = 3'd2;
	localparam logic [OP_W-1:0] OP_FLUSH       = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH_CLEAR = 3'd4;

	// internal command classes
	typedef logic [2:0] cmd_code_t;
	localparam cmd_code_t CMD_LOOKUP      = 3'd0;
	localparam cmd_code_t CMD_PLACE       = 3'd1;
	localparam cmd_code_t CMD_MARK        = 3'd2;
	localparam cmd_code_t CMD_FLUSH       = 3'd3;
	localparam cmd_code_t CMD_FLUSH_CLEAR = 3'd4;
	localparam cmd_code_t CMD_NOP         = 3'd5;

	// result kinds
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_LOOKUP    = 2'd0;
	localparam kind_t KIND_PLACED    = 2'd1;
	localparam kind_t KIND_WRITEBACK = 2'd2;
	localparam kind_t KIND_DONE      = 2'd3;

	// classified command held in the queue
	typedef struct packed {
		cmd_code_t             code;
		logic [ADDR_W-1:0]     page_address;
		logic [SEL_W-1:0]      slot_select;
		logic                  sel_ok;
		logic [HANDLE_W-1:0]   page_handle;
	} cmd_t;

endpackage

// ===== hdl/pcrw_req_if.sv =====
// Request channel: one operation word per handshake.
interface pcrw_req_if;
	logic                           valid;
	logic                           ready;
	logic [pcrw_pkg::OP_W-1:0]      operation;
	logic [pcrw_pkg::ADDR_W-1:0]    page_address;
	logic [pcrw_pkg::SEL_W-1:0]     slot_select;
	logic [pcrw_pkg::HANDLE_W-1:0]  page_handle;

	modport source (
		output valid, operation, page_address, slot_select, page_handle,
		input  ready
	);
	modport sink (
		input  valid, operation, page_address, slot_select, page_handle,
		output ready
	);
endinterface

// ===== hdl/pcrw_rsp_if.sv =====
// Result channel: one result word per handshake.
interface pcrw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [pcrw_pkg::KIND_W-1:0]    result_kind;
	logic                           hit;
	logic [pcrw_pkg::SEL_W-1:0]     slot;
	logic [pcrw_pkg::ADDR_W-1:0]    out_address;
	logic [pcrw_pkg::HANDLE_W-1:0]  out_handle;
	logic                           last;

	modport source (
		output valid, result_kind, hit, slot, out_address, out_handle, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, hit, slot, out_address, out_handle, last,
		output ready
	);
endinterface

// ===== hdl/page_cache_round_robin_writeback.sv =====
// Top level of the round-robin write-back page cache.
// A place that evicts a dirty slot sends its write-back word first; a flush
// writes back each dirty slot (one handle store read per write-back).
// A 2-entry queue buffers requests while the back end is busy.
// Reset: all slots invalid and clean, pointer zero; no clearing pass.
module page_cache_round_robin_writeback #(
	parameter int SLOTS = pcrw_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	pcrw_req_if.sink    req,
	pcrw_rsp_if.source  rsp
);

	logic            q_full;
	logic            q_push;
	logic            q_valid;
	logic            q_pop;
	pcrw_pkg::cmd_t  push_cmd;
	pcrw_pkg::cmd_t  head_cmd;

	// request classification
	pcrw_front #(
		.SLOTS (SLOTS)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (push_cmd)
	);

	// command queue
	pcrw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (head_cmd),
		.pop      (q_pop)
	);

	// cache execution
	pcrw_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (head_cmd),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

// ===== hdl/pcrw_front.sv =====
// Front end: takes request words and classifies them into queue commands.
module pcrw_front #(
	parameter int SLOTS = pcrw_pkg::SLOTS_DEFAULT
) (
	pcrw_req_if.sink        req,
	input  logic            q_full,
	output logic            q_push,
	output pcrw_pkg::cmd_t  q_cmd
);

	// accept whenever the queue has room
	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	// operation decode, payload and slot range check for mark dirty
	always_comb begin
		q_cmd.page_address = req.page_address;
		q_cmd.slot_select  = req.slot_select;
		q_cmd.page_handle  = req.page_handle;
		q_cmd.sel_ok = (pcrw_pkg::SLOT_CMP_W'(req.slot_select)
			< pcrw_pkg::SLOT_CMP_W'(SLOTS));
		unique case (req.operation)
			pcrw_pkg::OP_LOOKUP:      q_cmd.code = pcrw_pkg::CMD_LOOKUP;
			pcrw_pkg::OP_PLACE:       q_cmd.code = pcrw_pkg::CMD_PLACE;
			pcrw_pkg::OP_MARK_DIRTY:  q_cmd.code = pcrw_pkg::CMD_MARK;
			pcrw_pkg::OP_FLUSH:       q_cmd.code = pcrw_pkg::CMD_FLUSH;
			pcrw_pkg::OP_FLUSH_CLEAR: q_cmd.code = pcrw_pkg::CMD_FLUSH_CLEAR;
			default:                  q_cmd.code = pcrw_pkg::CMD_NOP;
		endcase
	end

endmodule

// ===== hdl/pcrw_queue.sv =====
// Short command queue decoupling the front end from the execution back end.
module pcrw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcrw_pkg::cmd_t  push_cmd,
	output logic            full,
	output logic            q_valid,
	output pcrw_pkg::cmd_t  q_cmd,
	input  logic            pop
);

	localparam int DEPTH = pcrw_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	pcrw_pkg::cmd_t  ent_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/pcrw_back.sv =====
// Back end: cache state, tag match, replacement search, flush walk and result register.
module pcrw_back #(
	parameter int SLOTS = pcrw_pkg::SLOTS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pcrw_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	pcrw_rsp_if.source      rsp
);

	localparam int SW = $clog2(SLOTS);
	localparam int AW = pcrw_pkg::ADDR_W;
	localparam int HW = pcrw_pkg::HANDLE_W;
	localparam int XW = pcrw_pkg::SEL_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EXEC     = 3'd1;
	localparam logic [2:0] ST_LOOK     = 3'd2;
	localparam logic [2:0] ST_WB       = 3'd3;
	localparam logic [2:0] ST_PLACE    = 3'd4;
	localparam logic [2:0] ST_FLUSH    = 3'd5;
	localparam logic [2:0] ST_FLUSH_WB = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	// next slot index, wrapping at the slot count
	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] x);
		logic [SW:0] s;
		s = {1'b0, x} + (SW + 1)'(1);
		if (s == (SW + 1)'(SLOTS)) begin
			s = '0;
		end
		return s[SW-1:0];
	endfunction

	// low bits of a slot index for the result word
	function automatic logic [XW-1:0] to_slot(input logic [SW-1:0] x);
		logic [SW+XW-1:0] w;
		w = {{XW{1'b0}}, x};
		return w[XW-1:0];
	endfunction

	logic [2:0]        state_q, state_d;
	pcrw_pkg::cmd_t    cmd_q;

	// cache state
	logic [SLOTS-1:0]  valid_q, valid_d;
	logic [SLOTS-1:0]  dirty_q, dirty_d;
	logic [SW-1:0]     ptr_q, ptr_d;
	logic [AW-1:0]     tag_q [SLOTS];
	logic [HW-1:0]     handle_mem [SLOTS];
	logic [HW-1:0]     rd_handle_q;

	// per-command context
	logic [SW-1:0]     ctx_idx_q, ctx_idx_d;
	logic              ctx_flag_q, ctx_flag_d;
	logic [AW-1:0]     tag_wb_q;
	logic              ctx_we;

	// output register
	logic                   out_valid_q;
	pcrw_pkg::kind_t        out_kind_q, o_kind;
	logic                   out_hit_q, o_hit;
	logic [XW-1:0]          out_slot_q, o_slot;
	logic [AW-1:0]          out_addr_q, o_addr;
	logic [HW-1:0]          out_handle_q, o_handle;
	logic                   out_last_q, o_last;
	logic                   out_load, out_free;

	// memory and tag write controls
	logic              mem_re, mem_we, tag_we;
	logic [SW-1:0]     mem_ra;
	logic              fin;

	// search results
	logic              hit_any, clean_any, dirty_any;
	logic [SW-1:0]     hit_idx, clean_idx, dirty_idx, pick_idx;
	logic [SW+XW-1:0]  sel_wide;
	logic [SW-1:0]     sel_idx;

	assign out_free = !out_valid_q || rsp.ready;
	assign sel_wide = {{SW{1'b0}}, cmd_q.slot_select};
	assign sel_idx  = sel_wide[SW-1:0];
	assign pick_idx = clean_any ? clean_idx : ptr_q;

	// tag match, first valid hit wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == cmd_q.page_address) begin
				hit_any = 1'b1;
				hit_idx = SW'(i);
			end
		end
	end

	// clean slot search from pointer+1 round to pointer-1
	always_comb begin
		logic [SW:0] s;
		clean_any = 1'b0;
		clean_idx = ptr_q;
		s         = '0;
		for (int k = SLOTS - 1; k >= 1; k--) begin
			s = {1'b0, ptr_q} + (SW + 1)'(k);
			if (s >= (SW + 1)'(SLOTS)) begin
				s = s - (SW + 1)'(SLOTS);
			end
			if (!dirty_q[s[SW-1:0]]) begin
				clean_any = 1'b1;
				clean_idx = s[SW-1:0];
			end
		end
	end

	// lowest dirty slot for the flush walk
	always_comb begin
		dirty_any = 1'b0;
		dirty_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (dirty_q[i]) begin
				dirty_any = 1'b1;
				dirty_idx = SW'(i);
			end
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		fin        = 1'b0;
		out_load   = 1'b0;
		o_kind     = pcrw_pkg::KIND_DONE;
		o_hit      = 1'b0;
		o_slot     = '0;
		o_addr     = '0;
		o_handle   = '0;
		o_last     = 1'b1;
		valid_d    = valid_q;
		dirty_d    = dirty_q;
		ptr_d      = ptr_q;
		tag_we     = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_ra     = ctx_idx_q;
		ctx_we     = 1'b0;
		ctx_idx_d  = ctx_idx_q;
		ctx_flag_d = ctx_flag_q;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q.code) inside
					pcrw_pkg::CMD_LOOKUP: begin
						ctx_we     = 1'b1;
						ctx_idx_d  = hit_idx;
						ctx_flag_d = hit_any;
						mem_re     = 1'b1;
						mem_ra     = hit_idx;
						state_d    = ST_LOOK;
					end
					pcrw_pkg::CMD_PLACE: begin
						ctx_we    = 1'b1;
						ctx_idx_d = pick_idx;
						mem_re    = 1'b1;
						mem_ra    = pick_idx;
						state_d   = (!clean_any && dirty_q[ptr_q]) ? ST_WB : ST_PLACE;
					end
					pcrw_pkg::CMD_MARK: begin
						if (cmd_q.sel_ok && valid_q[sel_idx]) begin
							dirty_d[sel_idx] = 1'b1;
						end
						state_d = ST_DONE;
					end
					pcrw_pkg::CMD_FLUSH, pcrw_pkg::CMD_FLUSH_CLEAR: begin
						state_d = ST_FLUSH;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_LOOK: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = pcrw_pkg::KIND_LOOKUP;
					o_hit    = ctx_flag_q;
					if (ctx_flag_q) begin
						o_slot   = to_slot(ctx_idx_q);
						o_addr   = cmd_q.page_address;
						o_handle = rd_handle_q;
						ptr_d    = wrap_inc(ctx_idx_q);
					end
					fin = 1'b1;
				end
			end
			ST_WB: begin
				// evicted dirty slot goes out before the placed word
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = pcrw_pkg::KIND_WRITEBACK;
					o_slot   = to_slot(ctx_idx_q);
					o_addr   = tag_wb_q;
					o_handle = rd_handle_q;
					o_last   = 1'b0;
					state_d  = ST_PLACE;
				end
			end
			ST_PLACE: begin
				if (out_free) begin
					out_load            = 1'b1;
					o_kind              = pcrw_pkg::KIND_PLACED;
					o_slot              = to_slot(ctx_idx_q);
					o_addr              = cmd_q.page_address;
					o_handle            = cmd_q.page_handle;
					tag_we              = 1'b1;
					mem_we              = 1'b1;
					valid_d[ctx_idx_q]  = 1'b1;
					dirty_d[ctx_idx_q]  = 1'b0;
					ptr_d               = wrap_inc(ctx_idx_q);
					fin                 = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (dirty_any) begin
					ctx_we    = 1'b1;
					ctx_idx_d = dirty_idx;
					mem_re    = 1'b1;
					mem_ra    = dirty_idx;
					state_d   = ST_FLUSH_WB;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FLUSH_WB: begin
				if (out_free) begin
					out_load           = 1'b1;
					o_kind             = pcrw_pkg::KIND_WRITEBACK;
					o_slot             = to_slot(ctx_idx_q);
					o_addr             = tag_wb_q;
					o_handle           = rd_handle_q;
					o_last             = 1'b0;
					dirty_d[ctx_idx_q] = 1'b0;
					state_d            = ST_FLUSH;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (cmd_q.code == pcrw_pkg::CMD_FLUSH
						|| cmd_q.code == pcrw_pkg::CMD_FLUSH_CLEAR) begin
						ptr_d = '0;
					end
					if (cmd_q.code == pcrw_pkg::CMD_FLUSH_CLEAR) begin
						valid_d = '0;
					end
					fin = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// last word of a command: take the next one straight away
		if (fin) begin
			if (q_valid) begin
				q_pop   = 1'b1;
				state_d = ST_EXEC;
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			dirty_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			dirty_q <= dirty_d;
			ptr_q   <= ptr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (ctx_we) begin
			ctx_idx_q  <= ctx_idx_d;
			ctx_flag_q <= ctx_flag_d;
			tag_wb_q   <= tag_q[ctx_idx_d];
		end
		if (tag_we) begin
			tag_q[ctx_idx_q] <= cmd_q.page_address;
		end
		if (out_load) begin
			out_kind_q   <= o_kind;
			out_hit_q    <= o_hit;
			out_slot_q   <= o_slot;
			out_addr_q   <= o_addr;
			out_handle_q <= o_handle;
			out_last_q   <= o_last;
		end
	end

	// handle store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			handle_mem[ctx_idx_q] <= cmd_q.page_handle;
		end
		if (mem_re) begin
			rd_handle_q <= handle_mem[mem_ra];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.slot        = out_slot_q;
	assign rsp.out_address = out_addr_q;
	assign rsp.out_handle  = out_handle_q;
	assign rsp.last        = out_last_q;

endmodule
